// ===== src/dcfw_pkg.sv =====
// ----------------------------------------------------------------------------
// dcfw_pkg
// shared types, constants and helpers of the drive command frame watchdog
// ----------------------------------------------------------------------------
package dcfw_pkg;

   localparam int FRAME_LEN  = 13;
   localparam int POS_W      = 4;
   localparam int BYTE_W     = 8;
   localparam int DUTY_W     = 25;
   localparam int MAG_W      = 24;
   localparam int WHOLE_W    = 14;
   localparam int FRAC_W     = 10;
   localparam int PERIOD_W   = 10;
   localparam int TIMEOUT_W  = 16;
   localparam int VALID_W    = 17;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 56;
   localparam int CSR_DATA_W = 16;

   localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 10'd10;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;
   localparam logic [PERIOD_W-1:0]  SEND_MAX      = '1;
   localparam logic [VALID_W-1:0]   VALID_MAX     = '1;

   // register indexes
   localparam logic REG_SEND_PERIOD = 1'b0;
   localparam logic REG_TIMEOUT     = 1'b1;

   // item kinds
   localparam logic ACT_BYTE = 1'b0;
   localparam logic ACT_TICK = 1'b1;

   localparam logic [1:0] KIND_DRIVE    = 2'd0;
   localparam logic [1:0] KIND_FRAME_OK = 2'd1;
   localparam logic [1:0] KIND_FRAME_BAD = 2'd2;

   localparam logic [1:0] MODE_MANUAL = 2'd0;
   localparam logic [1:0] MODE_AUTO   = 2'd1;
   localparam logic [1:0] MODE_STOP   = 2'd2;

   // characters
   localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
   localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
   localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
   localparam logic [BYTE_W-1:0] CH_M     = 8'h4D;
   localparam logic [BYTE_W-1:0] CH_C     = 8'h43;
   localparam logic [BYTE_W-1:0] CH_F     = 8'h46;
   localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CH_ONE   = 8'h31;
   localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CH_POINT = 8'h2E;

   // byte positions inside a frame
   localparam logic [POS_W-1:0] POS_START      = 4'd0;
   localparam logic [POS_W-1:0] POS_RIGHT_DIR  = 4'd1;
   localparam logic [POS_W-1:0] POS_LEFT_DIR   = 4'd6;
   localparam logic [POS_W-1:0] POS_LEFT_LAST  = 4'd10;
   localparam logic [POS_W-1:0] POS_TAIL_C     = 4'd11;
   localparam logic [POS_W-1:0] POS_TAIL_F     = 4'd12;

   localparam logic FIELD_RIGHT = 1'b0;
   localparam logic FIELD_LEFT  = 1'b1;

   typedef enum logic [1:0] {
      DIR_NONE,
      DIR_ZERO,
      DIR_ONE
   } dir_type;

   // parse record of one duty field
   typedef struct packed {
      dir_type              dir;
      logic [WHOLE_W-1:0]   whole;
      logic [FRAC_W-1:0]    frac;
      logic [1:0]           frac_cnt;
      logic                 seen_point;
      logic                 stopped;
   } field_rec_type;

   typedef struct packed {
      logic              wr_en;
      logic              addr;
      logic              start;
      logic [BYTE_W-1:0] data;
   } field_cmd_type;

   function automatic logic signed [DUTY_W-1:0] field_duty(field_rec_type rec, logic invert);
      logic [MAG_W-1:0]         mag;
      logic signed [DUTY_W-1:0] pos_v;
      mag   = MAG_W'(rec.whole) * MAG_W'(1000) + MAG_W'(rec.frac);
      pos_v = signed'({1'b0, mag});
      case (rec.dir)
         DIR_ZERO: field_duty = invert ? -pos_v : pos_v;
         DIR_ONE:  field_duty = invert ? pos_v : -pos_v;
         default:  field_duty = '0;
      endcase
   endfunction

endpackage

// ===== src/dcfw_field_unit.sv =====
// ----------------------------------------------------------------------------
// dcfw_field_unit
// two-entry record memory for the duty fields, read-modify-write with
// forwarding of a write that meets a read of the same entry
// ----------------------------------------------------------------------------
module dcfw_field_unit (
   input  logic                    clock,
   input  logic                    rd_en,
   input  logic                    rd_addr,
   input  dcfw_pkg::field_cmd_type cmd,
   output dcfw_pkg::field_rec_type rec
);
   import dcfw_pkg::*;

   field_rec_type field_mem_ff [2];
   field_rec_type rec_ff;
   field_rec_type rec_in;
   logic [3:0]        digit;
   logic [FRAC_W-1:0] frac_add;
   logic              is_digit;

   always_comb begin
      digit    = cmd.data[3:0];
      is_digit = (cmd.data >= CH_ZERO) && (cmd.data <= CH_NINE);
      case (rec_ff.frac_cnt)
         2'd0:    frac_add = FRAC_W'(digit) * FRAC_W'(100);
         2'd1:    frac_add = FRAC_W'(digit) * FRAC_W'(10);
         default: frac_add = FRAC_W'(digit);
      endcase
      rec_in = rec_ff;
      if (cmd.start) begin
         rec_in = '0;
         if (cmd.data == CH_ZERO) begin
            rec_in.dir = DIR_ZERO;
         end else if (cmd.data == CH_ONE) begin
            rec_in.dir = DIR_ONE;
         end else begin
            rec_in.dir = DIR_NONE;
         end
      end else if (!rec_ff.stopped) begin
         if (cmd.data == CH_POINT) begin
            if (rec_ff.seen_point) begin
               rec_in.stopped = 1'b1;
            end else begin
               rec_in.seen_point = 1'b1;
            end
         end else if (is_digit) begin
            if (rec_ff.seen_point) begin
               rec_in.frac     = rec_ff.frac + frac_add;
               rec_in.frac_cnt = rec_ff.frac_cnt + 2'd1;
            end else begin
               rec_in.whole = rec_ff.whole * WHOLE_W'(10) + WHOLE_W'(digit);
            end
         end else begin
            rec_in.stopped = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         field_mem_ff[cmd.addr] <= rec_in;
      end
      if (rd_en) begin
         if (cmd.wr_en && (cmd.addr == rd_addr)) begin
            rec_ff <= rec_in;
         end else begin
            rec_ff <= field_mem_ff[rd_addr];
         end
      end
   end

   assign rec = rec_ff;

endmodule

// ===== src/drive_command_frame_watchdog_top.sv =====
// ----------------------------------------------------------------------------
// drive_command_frame_watchdog_top
// frames serial bytes into drive commands, watches frame arrival and emits
// drive commands on the send period
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  req_    | in  | tuser: action; tdata: data_byte [7:0], estop_level [8]
//  rsp_    | out | tuser: result_kind; tdata: duty_right, duty_left, relay_cut,
//          |     |        manual_lamp, watchdog_expired, mode_now
//  csr_    | in  | csr_index: register, csr_data: value
//
//  one item per cycle while no waiting result holds the work stage; in the work
//  stage the field record, read from the record memory at acceptance, is updated
//  and written back, then any result it gives waits in the output register
//  the record memory is read at acceptance, a same-cycle write is forwarded
//  synchronous reset clears counters, mode, duties and the frame position
//  a waiting result holds the work stage; while the work stage is empty one
//  more item is taken into it
// ----------------------------------------------------------------------------
module drive_command_frame_watchdog_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // data_byte [7:0], estop_level [8]
   input  logic [dcfw_pkg::REQ_DATA_W-1:0]   req_tdata,
   // action [0]
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // duty_right [24:0], duty_left [49:25], relay_cut [50], manual_lamp [51],
   // watchdog_expired [52], mode_now [54:53]
   output logic [dcfw_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // result_kind [1:0]
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_index,
   input  logic [dcfw_pkg::CSR_DATA_W-1:0]   csr_data
);
   import dcfw_pkg::*;

   logic                     req_take;
   logic                     s1_fire;
   logic [POS_W-1:0]         pos_ff, pos_in;

   logic                     s1_valid_ff;
   logic                     s1_tick_ff;
   logic [BYTE_W-1:0]        s1_byte_ff;
   logic                     s1_estop_ff;
   logic [POS_W-1:0]         s1_pos_ff;

   logic [PERIOD_W-1:0]      period_ff;
   logic [TIMEOUT_W-1:0]     timeout_ff;

   logic [1:0]               mode_ff, mode_in;
   logic signed [DUTY_W-1:0] want_r_ff, want_r_in;
   logic signed [DUTY_W-1:0] want_l_ff, want_l_in;
   logic [VALID_W-1:0]       tv_ff, tv_in, tv_inc;
   logic [PERIOD_W-1:0]      ts_ff, ts_in, ts_inc;
   logic                     lamp_ff, lamp_in;
   logic [BYTE_W-1:0]        start_ff, start_in;
   logic                     tail_c_ff, tail_c_in;
   logic signed [DUTY_W-1:0] right_val_ff, right_val_in;

   logic                     rsp_valid_ff;
   logic [1:0]               rsp_kind_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;

   logic                     emit;
   logic [1:0]               kind;
   logic signed [DUTY_W-1:0] out_r, out_l;
   logic                     relay;
   logic                     expired;
   logic                     frame_ok;
   logic                     start_ok;

   field_cmd_type            fcmd;
   field_rec_type            frec;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_take   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign pos_in = (pos_ff == POS_TAIL_F) ? '0 : pos_ff + POS_W'(1);

   // record memory port
   assign fcmd.wr_en = s1_fire && !s1_tick_ff && (s1_pos_ff >= POS_RIGHT_DIR)
                       && (s1_pos_ff <= POS_LEFT_LAST);
   assign fcmd.addr  = (s1_pos_ff >= POS_LEFT_DIR) ? FIELD_LEFT : FIELD_RIGHT;
   assign fcmd.start = (s1_pos_ff == POS_RIGHT_DIR) || (s1_pos_ff == POS_LEFT_DIR);
   assign fcmd.data  = s1_byte_ff;

   dcfw_field_unit u_field (
      .clock   (clock),
      .rd_en   (req_take && (req_tuser == ACT_BYTE)),
      .rd_addr ((pos_ff inside {[POS_LEFT_DIR:POS_LEFT_LAST], POS_TAIL_F})
                ? FIELD_LEFT : FIELD_RIGHT),
      .cmd     (fcmd),
      .rec     (frec)
   );

   always_comb begin
      tv_inc   = (tv_ff == VALID_MAX) ? tv_ff : tv_ff + VALID_W'(1);
      ts_inc   = (ts_ff == SEND_MAX) ? ts_ff : ts_ff + PERIOD_W'(1);
      start_ok = start_ff inside {CH_S, CH_E, CH_A, CH_M};
      frame_ok = start_ok && tail_c_ff && (s1_byte_ff == CH_F);

      mode_in      = mode_ff;
      want_r_in    = want_r_ff;
      want_l_in    = want_l_ff;
      tv_in        = tv_ff;
      ts_in        = ts_ff;
      lamp_in      = lamp_ff;
      start_in     = start_ff;
      tail_c_in    = tail_c_ff;
      right_val_in = right_val_ff;
      emit         = 1'b0;
      kind         = KIND_DRIVE;
      out_r        = '0;
      out_l        = '0;
      relay        = 1'b0;

      if (s1_tick_ff) begin
         tv_in = tv_inc;
         ts_in = ts_inc;
         if (ts_inc >= period_ff) begin
            ts_in = '0;
            emit  = 1'b1;
            if ((tv_inc > VALID_W'(timeout_ff)) || s1_estop_ff || (mode_ff == MODE_STOP)) begin
               relay = 1'b1;
            end else begin
               lamp_in = (mode_ff == MODE_MANUAL);
               out_r   = want_r_ff;
               out_l   = want_l_ff;
            end
         end
      end else begin
         case (s1_pos_ff)
            POS_START: begin
               start_in = s1_byte_ff;
            end
            POS_TAIL_C: begin
               tail_c_in    = (s1_byte_ff == CH_C);
               right_val_in = field_duty(frec, 1'b0);
            end
            POS_TAIL_F: begin
               emit = 1'b1;
               if (frame_ok) begin
                  kind      = KIND_FRAME_OK;
                  tv_in     = '0;
                  want_r_in = right_val_ff;
                  want_l_in = field_duty(frec, 1'b1);
                  if (start_ff == CH_E) begin
                     mode_in = MODE_STOP;
                  end else if (start_ff == CH_A) begin
                     mode_in = MODE_AUTO;
                  end else begin
                     mode_in = MODE_MANUAL;
                  end
               end else begin
                  kind = KIND_FRAME_BAD;
               end
               out_r = want_r_in;
               out_l = want_l_in;
            end
            default: ;
         endcase
      end
      expired = tv_in > VALID_W'(timeout_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         period_ff    <= PERIOD_RESET;
         timeout_ff   <= TIMEOUT_RESET;
         mode_ff      <= MODE_MANUAL;
         want_r_ff    <= '0;
         want_l_ff    <= '0;
         tv_ff        <= '0;
         ts_ff        <= '0;
         lamp_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_SEND_PERIOD: period_ff  <= csr_data[PERIOD_W-1:0];
               REG_TIMEOUT:     timeout_ff <= csr_data[TIMEOUT_W-1:0];
               default: ;
            endcase
         end
         if (req_take && (req_tuser == ACT_BYTE)) begin
            pos_ff <= pos_in;
         end
         if (req_take) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_fire) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_fire) begin
            mode_ff   <= mode_in;
            want_r_ff <= want_r_in;
            want_l_ff <= want_l_in;
            tv_ff     <= tv_in;
            ts_ff     <= ts_in;
            lamp_ff   <= lamp_in;
         end
         if (s1_fire && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_tick_ff  <= req_tuser;
         s1_byte_ff  <= req_tdata[BYTE_W-1:0];
         s1_estop_ff <= req_tdata[BYTE_W];
         s1_pos_ff   <= pos_ff;
      end
      if (s1_fire) begin
         start_ff     <= start_in;
         tail_c_ff    <= tail_c_in;
         right_val_ff <= right_val_in;
      end
      if (s1_fire && emit) begin
         rsp_kind_ff <= kind;
         rsp_data_ff <= {1'b0, mode_in, expired, lamp_in, relay, out_l, out_r};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_TAIL_F)
      else $error("frame position out of range");

   a_frame_ok_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_kind_ff == KIND_FRAME_OK) |-> !rsp_data_ff[50] && !rsp_data_ff[52])
      else $error("accepted frame shows relay cut or expired watchdog");

   a_cut_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[50] |-> (rsp_data_ff[49:0] == '0))
      else $error("relay cut with nonzero duty");

   a_send_restart: assert property (@(posedge clock) disable iff (reset)
      s1_fire && s1_tick_ff && emit |=> (ts_ff == '0))
      else $error("send counter not restarted after drive command");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_kind_ff == KIND_DRIVE) || (rsp_kind_ff == KIND_FRAME_OK)
                       || (rsp_kind_ff == KIND_FRAME_BAD))
      else $error("illegal result kind");

endmodule
